// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the checker files
// no dependencies; each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define AST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define AST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/ats_pkg.sv -----
// types, codes and character helpers for the assembly token scanner
// no dependencies
package ats_pkg;

  localparam int POSITION_BITS = 32;
  localparam int LINE_BITS     = 32;

  localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
  localparam logic [LINE_BITS-1:0]     LINE_MAX = '1;

  typedef enum logic [3:0] {
    K_EOF = 4'd0, K_NEWLINE = 4'd1, K_COMMA = 4'd2, K_LBRACKET = 4'd3,
    K_RBRACKET = 4'd4, K_PLUS = 4'd5, K_MINUS = 4'd6, K_STAR = 4'd7,
    K_COLON = 4'd8, K_STRING = 4'd9, K_DIRECTIVE = 4'd10, K_IDENT = 4'd11,
    K_INTEGER = 4'd12, K_ERROR = 4'd13
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE = 3'd0, E_MALFORMED = 3'd1, E_UNTERM = 3'd2, E_UNTERM_ESC = 3'd3,
    E_LONE_DOT = 3'd4, E_UNEXPECTED = 3'd5, E_OVERFLOW = 3'd6
  } errc_t;

  typedef enum logic [1:0] {
    B_DEC = 2'd0, B_HEX = 2'd1, B_BIN = 2'd2, B_OCT = 2'd3
  } base_t;

  typedef enum logic [9:0] {
    M_IDLE      = 10'b0000000001,
    M_COMMENT   = 10'b0000000010,
    M_STRING    = 10'b0000000100,
    M_STR_ESC   = 10'b0000001000,
    M_DOT       = 10'b0000010000,
    M_ZERO      = 10'b0000100000,
    M_NUMBER    = 10'b0001000000,
    M_MALFORMED = 10'b0010000000,
    M_IDENT     = 10'b0100000000,
    M_DIRECT    = 10'b1000000000
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [2:0]  error_code;
    logic [31:0] token_offset;
    logic [31:0] token_length;
    logic [31:0] token_line;
    logic [31:0] token_column;
    logic [63:0] num_value;
    logic        num_overflow;
    logic        error_flag;
    logic        last;
  } out_item_t;

  // two results at most per item
  typedef struct packed {
    logic      vld0;
    logic      vld1;
    out_item_t tok0;
    out_item_t tok1;
  } tok_pair_t;

  function automatic logic chr_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic chr_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_id_start(input logic [7:0] c);
    return chr_letter(c) || c == "_";
  endfunction

  function automatic logic is_id_cont(input logic [7:0] c);
    return is_id_start(c) || chr_num(c);
  endfunction

endpackage

// ----- rtl/core/ats_core.sv -----
// scanner state and per-byte lexing step
// depends on ats_pkg
module ats_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  ats_pkg::in_item_t  item,
  output ats_pkg::tok_pair_t toks
);

  ats_pkg::mode_t                        mode_r, mode_nxt;
  logic [ats_pkg::POSITION_BITS-1:0]     pos_r, pos_nxt, tst_r, tst_nxt;
  logic [ats_pkg::LINE_BITS-1:0]         line_r, line_nxt, col_r, col_nxt;
  logic [ats_pkg::LINE_BITS-1:0]         sln_r, sln_nxt, scol_r, scol_nxt;
  logic [63:0]                           acc_r, acc_nxt;
  logic                                  ovf_r, ovf_nxt;
  ats_pkg::base_t                        base_r, base_nxt;
  logic                                  pfx_r, pfx_nxt, dig_r, dig_nxt;
  logic                                  err_r, err_nxt;

  logic [7:0]     c;
  logic           taken;
  // pending-token slot (a) and single-byte or eof slot (b)
  logic           a_vld, b_vld;
  ats_pkg::kind_t a_kind, b_kind;
  ats_pkg::errc_t a_code, b_code;
  logic [ats_pkg::POSITION_BITS-1:0] a_len;
  logic           a_len1, b_len1;
  logic [63:0]    a_val;
  logic           a_ovf;
  logic           es_a, es_b;
  logic [5:0]     dv;
  logic           dv_ok;
  logic [67:0]    prod, sum;
  ats_pkg::out_item_t ta, tb;

  // digit value and the next accumulator
  always_comb begin
    dv = 6'd63;
    if (ats_pkg::chr_num(c))                 dv = 6'(c - "0");
    else if (c >= "a" && c <= "z")           dv = 6'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "Z")           dv = 6'(c - "A" + 8'd10);
    case (base_r)
      ats_pkg::B_HEX: dv_ok = dv < 6'd16;
      ats_pkg::B_BIN: dv_ok = dv < 6'd2;
      ats_pkg::B_OCT: dv_ok = dv < 6'd8;
      default:        dv_ok = dv < 6'd10;
    endcase
    case (base_r)
      ats_pkg::B_HEX: prod = {acc_r, 4'b0};
      ats_pkg::B_BIN: prod = {3'b0, acc_r, 1'b0};
      ats_pkg::B_OCT: prod = {1'b0, acc_r, 3'b0};
      default:        prod = {1'b0, acc_r, 3'b0} + {3'b0, acc_r, 1'b0};
    endcase
    sum = prod + 68'(dv);
  end

  always_comb begin
    c        = item.data_byte;
    mode_nxt = mode_r;
    tst_nxt  = tst_r;
    sln_nxt  = sln_r;
    scol_nxt = scol_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    base_nxt = base_r;
    pfx_nxt  = pfx_r;
    dig_nxt  = dig_r;
    taken    = 1'b0;
    a_vld    = 1'b0;
    a_kind   = ats_pkg::K_ERROR;
    a_code   = ats_pkg::E_NONE;
    a_len    = pos_r - tst_r;
    a_len1   = 1'b0;
    a_val    = '0;
    a_ovf    = 1'b0;
    b_vld    = 1'b0;
    b_kind   = ats_pkg::K_EOF;
    b_code   = ats_pkg::E_NONE;
    b_len1   = 1'b1;

    if (item.end_of_input) begin
      a_vld = 1'b1;
      case (mode_r)
        ats_pkg::M_STRING:    a_code = ats_pkg::E_UNTERM;
        ats_pkg::M_STR_ESC:   a_code = ats_pkg::E_UNTERM_ESC;
        ats_pkg::M_DOT: begin
          a_code = ats_pkg::E_LONE_DOT;
          a_len1 = 1'b1;
        end
        ats_pkg::M_ZERO, ats_pkg::M_NUMBER: begin
          if (pfx_r && !dig_r) begin
            a_code = ats_pkg::E_MALFORMED;
          end else begin
            a_kind = ats_pkg::K_INTEGER;
            a_code = ovf_r ? ats_pkg::E_OVERFLOW : ats_pkg::E_NONE;
            a_val  = ovf_r ? '1 : acc_r;
            a_ovf  = ovf_r;
          end
        end
        ats_pkg::M_MALFORMED: a_code = ats_pkg::E_MALFORMED;
        ats_pkg::M_IDENT:     a_kind = ats_pkg::K_IDENT;
        ats_pkg::M_DIRECT:    a_kind = ats_pkg::K_DIRECTIVE;
        default:              a_vld  = 1'b0;
      endcase
      mode_nxt = ats_pkg::M_IDLE;
      b_vld    = 1'b1;
      b_len1   = 1'b0;
    end else begin
      case (mode_r)
        ats_pkg::M_COMMENT: begin
          if (c == 8'h0a) mode_nxt = ats_pkg::M_IDLE;
          else            taken    = 1'b1;
        end
        ats_pkg::M_STRING: begin
          if (c == 8'h0a) begin
            a_vld    = 1'b1;
            a_code   = ats_pkg::E_UNTERM;
            mode_nxt = ats_pkg::M_IDLE;
          end else if (c == "\"") begin
            a_vld    = 1'b1;
            a_kind   = ats_pkg::K_STRING;
            a_len    = pos_r - tst_r + 1'b1;
            mode_nxt = ats_pkg::M_IDLE;
            taken    = 1'b1;
          end else begin
            if (c == "\\") mode_nxt = ats_pkg::M_STR_ESC;
            taken = 1'b1;
          end
        end
        ats_pkg::M_STR_ESC: begin
          if (c == 8'h0a) begin
            a_vld    = 1'b1;
            a_code   = ats_pkg::E_UNTERM_ESC;
            mode_nxt = ats_pkg::M_IDLE;
          end else begin
            mode_nxt = ats_pkg::M_STRING;
            taken    = 1'b1;
          end
        end
        ats_pkg::M_DOT: begin
          if (ats_pkg::is_id_start(c)) begin
            mode_nxt = ats_pkg::M_DIRECT;
            taken    = 1'b1;
          end else begin
            a_vld    = 1'b1;
            a_code   = ats_pkg::E_LONE_DOT;
            a_len1   = 1'b1;
            mode_nxt = ats_pkg::M_IDLE;
          end
        end
        ats_pkg::M_ZERO: begin
          mode_nxt = ats_pkg::M_NUMBER;
          if (c == "x" || c == "X" || c == "b" || c == "B" || c == "o" || c == "O") begin
            base_nxt = (c == "x" || c == "X") ? ats_pkg::B_HEX :
                       ((c == "b" || c == "B") ? ats_pkg::B_BIN : ats_pkg::B_OCT);
            pfx_nxt  = 1'b1;
            dig_nxt  = 1'b0;
            taken    = 1'b1;
          end
        end
        default: ;
      endcase

      if (!taken && mode_nxt == ats_pkg::M_NUMBER) begin
        taken = 1'b1;
        if (dv_ok) begin
          dig_nxt = 1'b1;
          if (sum[67:64] != 4'd0) ovf_nxt = 1'b1;
          else                    acc_nxt = sum[63:0];
        end else if (ats_pkg::is_id_cont(c)) begin
          mode_nxt = ats_pkg::M_MALFORMED;
        end else begin
          // pfx_nxt/dig_nxt equal the registered flags here
          a_vld = 1'b1;
          if (pfx_nxt && !dig_nxt) begin
            a_code = ats_pkg::E_MALFORMED;
          end else begin
            a_kind = ats_pkg::K_INTEGER;
            a_code = ovf_r ? ats_pkg::E_OVERFLOW : ats_pkg::E_NONE;
            a_val  = ovf_r ? '1 : acc_r;
            a_ovf  = ovf_r;
          end
          mode_nxt = ats_pkg::M_IDLE;
          taken    = 1'b0;
        end
      end else if (!taken && (mode_nxt == ats_pkg::M_MALFORMED ||
                              mode_nxt == ats_pkg::M_IDENT ||
                              mode_nxt == ats_pkg::M_DIRECT)) begin
        if (ats_pkg::is_id_cont(c)) begin
          taken = 1'b1;
        end else begin
          a_vld = 1'b1;
          if (mode_nxt == ats_pkg::M_MALFORMED) a_code = ats_pkg::E_MALFORMED;
          else if (mode_nxt == ats_pkg::M_IDENT) a_kind = ats_pkg::K_IDENT;
          else a_kind = ats_pkg::K_DIRECTIVE;
          mode_nxt = ats_pkg::M_IDLE;
        end
      end

      if (!taken) begin
        tst_nxt  = pos_r;
        sln_nxt  = line_r;
        scol_nxt = col_r;
        b_vld    = 1'b1;
        case (c)
          " ", 8'h09, 8'h0d: b_vld = 1'b0;
          ";": begin
            b_vld    = 1'b0;
            mode_nxt = ats_pkg::M_COMMENT;
          end
          8'h0a: b_kind = ats_pkg::K_NEWLINE;
          ",":   b_kind = ats_pkg::K_COMMA;
          "[":   b_kind = ats_pkg::K_LBRACKET;
          "]":   b_kind = ats_pkg::K_RBRACKET;
          "+":   b_kind = ats_pkg::K_PLUS;
          "-":   b_kind = ats_pkg::K_MINUS;
          "*":   b_kind = ats_pkg::K_STAR;
          ":":   b_kind = ats_pkg::K_COLON;
          "\"": begin
            b_vld    = 1'b0;
            mode_nxt = ats_pkg::M_STRING;
          end
          ".": begin
            b_vld    = 1'b0;
            mode_nxt = ats_pkg::M_DOT;
          end
          default: begin
            if (ats_pkg::chr_num(c)) begin
              b_vld    = 1'b0;
              mode_nxt = (c == "0") ? ats_pkg::M_ZERO : ats_pkg::M_NUMBER;
              acc_nxt  = 64'(c - "0");
              ovf_nxt  = 1'b0;
              base_nxt = ats_pkg::B_DEC;
              pfx_nxt  = 1'b0;
              dig_nxt  = 1'b1;
            end else if (ats_pkg::is_id_start(c)) begin
              b_vld    = 1'b0;
              mode_nxt = ats_pkg::M_IDENT;
            end else begin
              b_kind = ats_pkg::K_ERROR;
              b_code = ats_pkg::E_UNEXPECTED;
            end
          end
        endcase
      end
    end

    pos_nxt  = (pos_r < ats_pkg::POS_MAX) ? pos_r + 1'b1 : pos_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    if (!item.end_of_input) begin
      if (c == 8'h0a) begin
        if (line_r < ats_pkg::LINE_MAX) line_nxt = line_r + 1'b1;
        col_nxt = ats_pkg::LINE_BITS'(1);
      end else if (col_r < ats_pkg::LINE_MAX) begin
        col_nxt = col_r + 1'b1;
      end
    end else begin
      pos_nxt = pos_r;
    end
  end

  // assemble the results with the sticky error flag in order
  always_comb begin
    es_a = err_r | (a_vld && (a_kind == ats_pkg::K_ERROR || a_code == ats_pkg::E_OVERFLOW));
    es_b = es_a | (b_vld && b_kind == ats_pkg::K_ERROR);
    err_nxt = es_b;

    ta.token_kind   = a_kind;
    ta.error_code   = a_code;
    ta.token_offset = 32'(tst_r);
    ta.token_length = a_len1 ? 32'd1 : 32'(a_len);
    ta.token_line   = 32'(sln_r);
    ta.token_column = 32'(scol_r);
    ta.num_value    = a_val;
    ta.num_overflow = a_ovf;
    ta.error_flag   = es_a;
    ta.last         = !b_vld;

    tb.token_kind   = b_kind;
    tb.error_code   = b_code;
    tb.token_offset = 32'(pos_r);
    tb.token_length = b_len1 ? 32'd1 : 32'd0;
    tb.token_line   = 32'(line_r);
    tb.token_column = 32'(col_r);
    tb.num_value    = '0;
    tb.num_overflow = 1'b0;
    tb.error_flag   = es_b;
    tb.last         = 1'b1;

    toks.vld0 = a_vld | b_vld;
    toks.vld1 = a_vld & b_vld;
    toks.tok0 = a_vld ? ta : tb;
    toks.tok1 = tb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ats_pkg::M_IDLE;
      pos_r  <= '0;
      line_r <= ats_pkg::LINE_BITS'(1);
      col_r  <= ats_pkg::LINE_BITS'(1);
      tst_r  <= '0;
      sln_r  <= ats_pkg::LINE_BITS'(1);
      scol_r <= ats_pkg::LINE_BITS'(1);
      acc_r  <= '0;
      ovf_r  <= 1'b0;
      base_r <= ats_pkg::B_DEC;
      pfx_r  <= 1'b0;
      dig_r  <= 1'b0;
      err_r  <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      tst_r  <= tst_nxt;
      sln_r  <= sln_nxt;
      scol_r <= scol_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
      base_r <= base_nxt;
      pfx_r  <= pfx_nxt;
      dig_r  <= dig_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

// ----- rtl/core/ats_outq.sv -----
// four-entry result queue, takes up to two results per cycle while it has room for two
// depends on ats_pkg
module ats_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ats_pkg::tok_pair_t toks,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output ats_pkg::out_item_t out_data
);

  ats_pkg::out_item_t mem_r [4];
  logic [1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] n_in;

  assign out_valid = cnt_r != 3'd0;
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid && !out_stall;
  assign room      = cnt_r <= 3'd2;
  assign n_in      = push ? {1'b0, toks.vld0} + {1'b0, toks.vld1} : 2'd0;

  always_comb begin
    wr_nxt  = wr_r + n_in;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, n_in} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push && toks.vld0) mem_r[wr_r] <= toks.tok0;
    if (push && toks.vld1) mem_r[wr_r + 2'd1] <= toks.tok1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/assembly_token_scanner.sv -----
// channel   | direction | payload
// in_*      | input     | ats_pkg::in_item_t  (data_byte, end_of_input)
// out_*     | output    | ats_pkg::out_item_t (one token per transfer)
//
// one byte per cycle while in_stall is low: a transfer lands in the input
// register and is lexed from there into the queue. the lexing step runs once
// the four-entry queue has room for two tokens, so bytes giving two tokens are
// paced by the output at one token a cycle while out_stall is low.
// reset (rst_n low, synchronous) clears scanner state and empties the queue.
// out_stall holds the queue head; in_stall rises while a byte waits in the
// input register and the queue holds more than two tokens.
// depends on ats_pkg, ats_core, ats_outq
module assembly_token_scanner (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ats_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ats_pkg::out_item_t out_data
);

  ats_pkg::in_item_t  item_r;
  logic               vld_r;
  logic               room, step;
  ats_pkg::tok_pair_t toks;

  assign step     = vld_r && room;
  assign in_stall = vld_r && !room;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)         vld_r <= 1'b0;
    else if (!in_stall) vld_r <= in_valid;
  end

  ats_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .toks  (toks)
  );

  ats_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .toks      (toks),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/ats_checker.sv -----
// port-level checks for the token scanner, bound to the top level
// depends on ats_pkg and assert_macros.svh
`include "assert_macros.svh"

module ats_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input ats_pkg::out_item_t out_data
);

  `AST_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `AST_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_data), "stalled result changed")
  `AST_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result shown after reset")
  `AST_ASSERT(a_eof_last, out_valid && out_data.token_kind == ats_pkg::K_EOF |-> out_data.last, "eof not last")
  `AST_ASSERT(a_err_sticky, out_valid && (out_data.token_kind == ats_pkg::K_ERROR || out_data.num_overflow) |-> out_data.error_flag, "error flag missing")

endmodule

bind assembly_token_scanner ats_checker u_ats_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/sv/tb_assembly_token_scanner.sv -----
// self-checking testbench for assembly_token_scanner: byte streams in, tokens out
// predicts every token in a local lexer model and compares field by field
// depends on ats_pkg and the assembly_token_scanner rtl
module tb_assembly_token_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;

  typedef enum int {
    S_IDLE, S_COMMENT, S_STRING, S_STR_ESC, S_DOT, S_ZERO, S_NUMBER,
    S_MALFORMED, S_IDENT, S_DIRECT
  } lex_state_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ats_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ats_pkg::out_item_t out_data;

  assembly_token_scanner DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  // lexer model state
  lex_state_t  lx_state = S_IDLE;
  logic [31:0] lx_pos = 0, lx_line = 1, lx_col = 1;
  logic [31:0] lx_tok_start = 0, lx_tok_line = 1, lx_tok_col = 1;
  logic [63:0] lx_accum = 0;
  logic        lx_ovf = 0, lx_prefix = 0, lx_digit = 0, lx_err = 0;
  int unsigned lx_radix = 10;

  ats_pkg::out_item_t token_queue[$];
  ats_pkg::out_item_t step_tokens[$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          tokens_seen = 0;
  int          idle_cycles = 0;
  bit          hold_off = 0;
  bit          rx_random = 1;

  function automatic bit c_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit c_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit c_idstart(logic [7:0] c);
    return c_alpha(c) || c == "_";
  endfunction
  function automatic bit c_idcont(logic [7:0] c);
    return c_idstart(c) || c_digit(c);
  endfunction

  function automatic int unsigned digit_val(logic [7:0] c, int unsigned r);
    int unsigned v;
    if (c_digit(c)) v = c - "0";
    else if (c >= "a" && c <= "z") v = 10 + c - "a";
    else if (c >= "A" && c <= "Z") v = 10 + c - "A";
    else return 99;
    return v < r ? v : 99;
  endfunction

  function automatic void emit_token(ats_pkg::kind_t k, ats_pkg::errc_t e, logic [31:0] off,
                                     logic [31:0] len, logic [31:0] ln, logic [31:0] col,
                                     logic [63:0] val, logic ovf);
    ats_pkg::out_item_t t;
    if (k == ats_pkg::K_ERROR || e == ats_pkg::E_OVERFLOW) lx_err = 1;
    t.token_kind = k;
    t.error_code = e;
    t.token_offset = off;
    t.token_length = len;
    t.token_line = ln;
    t.token_column = col;
    t.num_value = val;
    t.num_overflow = ovf;
    t.error_flag = lx_err;
    t.last = 0;
    step_tokens.push_back(t);
  endfunction

  function automatic void emit_pending(ats_pkg::kind_t k, ats_pkg::errc_t e, logic [63:0] val,
                                       logic ovf);
    emit_token(k, e, lx_tok_start, lx_pos - lx_tok_start, lx_tok_line, lx_tok_col, val, ovf);
  endfunction

  function automatic void emit_integer();
    if (lx_ovf) emit_pending(ats_pkg::K_INTEGER, ats_pkg::E_OVERFLOW, '1, 1);
    else emit_pending(ats_pkg::K_INTEGER, ats_pkg::E_NONE, lx_accum, 0);
  endfunction

  function automatic void finish_number();
    if (lx_prefix && !lx_digit) emit_pending(ats_pkg::K_ERROR, ats_pkg::E_MALFORMED, 0, 0);
    else emit_integer();
  endfunction

  // advance the lexer model by one item, queueing the tokens it yields
  function automatic void lex_item(ats_pkg::in_item_t it);
    logic [7:0] c;
    bit taken;
    int unsigned d;
    ats_pkg::kind_t k;
    bit single;
    c = it.data_byte;
    taken = 0;
    step_tokens.delete();
    if (it.end_of_input) begin
      case (lx_state)
        S_STRING: emit_pending(ats_pkg::K_ERROR, ats_pkg::E_UNTERM, 0, 0);
        S_STR_ESC: emit_pending(ats_pkg::K_ERROR, ats_pkg::E_UNTERM_ESC, 0, 0);
        S_DOT: emit_token(ats_pkg::K_ERROR, ats_pkg::E_LONE_DOT, lx_tok_start, 1, lx_tok_line,
                          lx_tok_col, 0, 0);
        S_ZERO: emit_integer();
        S_NUMBER: finish_number();
        S_MALFORMED: emit_pending(ats_pkg::K_ERROR, ats_pkg::E_MALFORMED, 0, 0);
        S_IDENT: emit_pending(ats_pkg::K_IDENT, ats_pkg::E_NONE, 0, 0);
        S_DIRECT: emit_pending(ats_pkg::K_DIRECTIVE, ats_pkg::E_NONE, 0, 0);
        default: ;
      endcase
      lx_state = S_IDLE;
      emit_token(ats_pkg::K_EOF, ats_pkg::E_NONE, lx_pos, 0, lx_line, lx_col, 0, 0);
    end else begin
      case (lx_state)
        S_COMMENT: if (c == "\n") lx_state = S_IDLE; else taken = 1;
        S_STRING: begin
          if (c == "\n") begin
            emit_pending(ats_pkg::K_ERROR, ats_pkg::E_UNTERM, 0, 0);
            lx_state = S_IDLE;
          end else if (c == "\"") begin
            emit_token(ats_pkg::K_STRING, ats_pkg::E_NONE, lx_tok_start,
                       lx_pos + 1 - lx_tok_start, lx_tok_line, lx_tok_col, 0, 0);
            lx_state = S_IDLE;
            taken = 1;
          end else begin
            if (c == "\\") lx_state = S_STR_ESC;
            taken = 1;
          end
        end
        S_STR_ESC: begin
          if (c == "\n") begin
            emit_pending(ats_pkg::K_ERROR, ats_pkg::E_UNTERM_ESC, 0, 0);
            lx_state = S_IDLE;
          end else begin
            lx_state = S_STRING;
            taken = 1;
          end
        end
        S_DOT: begin
          if (c_idstart(c)) begin
            lx_state = S_DIRECT;
            taken = 1;
          end else begin
            emit_token(ats_pkg::K_ERROR, ats_pkg::E_LONE_DOT, lx_tok_start, 1, lx_tok_line,
                       lx_tok_col, 0, 0);
            lx_state = S_IDLE;
          end
        end
        S_ZERO: begin
          if (c inside {"x", "X", "b", "B", "o", "O"}) begin
            lx_radix = (c == "x" || c == "X") ? 16 : ((c == "b" || c == "B") ? 2 : 8);
            lx_prefix = 1;
            lx_digit = 0;
            taken = 1;
          end
          lx_state = S_NUMBER;
        end
        default: ;
      endcase

      if (!taken && lx_state == S_NUMBER) begin
        d = digit_val(c, lx_radix);
        taken = 1;
        if (d != 99) begin
          lx_digit = 1;
          if (lx_accum > (64'hFFFF_FFFF_FFFF_FFFF - d) / lx_radix) lx_ovf = 1;
          else lx_accum = lx_accum * lx_radix + d;
        end else if (c_idcont(c)) begin
          lx_state = S_MALFORMED;
        end else begin
          finish_number();
          lx_state = S_IDLE;
          taken = 0;
        end
      end else if (!taken && lx_state inside {S_MALFORMED, S_IDENT, S_DIRECT}) begin
        if (c_idcont(c)) begin
          taken = 1;
        end else begin
          if (lx_state == S_MALFORMED) emit_pending(ats_pkg::K_ERROR, ats_pkg::E_MALFORMED, 0, 0);
          else if (lx_state == S_IDENT) emit_pending(ats_pkg::K_IDENT, ats_pkg::E_NONE, 0, 0);
          else emit_pending(ats_pkg::K_DIRECTIVE, ats_pkg::E_NONE, 0, 0);
          lx_state = S_IDLE;
        end
      end

      if (!taken) begin
        lx_tok_start = lx_pos;
        lx_tok_line = lx_line;
        lx_tok_col = lx_col;
        single = 1;
        k = ats_pkg::K_EOF;
        case (c)
          " ", "\t", "\r": single = 0;
          ";": begin lx_state = S_COMMENT; single = 0; end
          "\n": k = ats_pkg::K_NEWLINE;
          ",": k = ats_pkg::K_COMMA;
          "[": k = ats_pkg::K_LBRACKET;
          "]": k = ats_pkg::K_RBRACKET;
          "+": k = ats_pkg::K_PLUS;
          "-": k = ats_pkg::K_MINUS;
          "*": k = ats_pkg::K_STAR;
          ":": k = ats_pkg::K_COLON;
          "\"": begin lx_state = S_STRING; single = 0; end
          ".": begin lx_state = S_DOT; single = 0; end
          default: begin
            single = 0;
            if (c_digit(c)) begin
              lx_state = (c == "0") ? S_ZERO : S_NUMBER;
              lx_accum = c - "0";
              lx_ovf = 0;
              lx_radix = 10;
              lx_prefix = 0;
              lx_digit = 1;
            end else if (c_idstart(c)) begin
              lx_state = S_IDENT;
            end else begin
              emit_token(ats_pkg::K_ERROR, ats_pkg::E_UNEXPECTED, lx_tok_start, 1, lx_tok_line,
                         lx_tok_col, 0, 0);
            end
          end
        endcase
        if (single) emit_token(k, ats_pkg::E_NONE, lx_tok_start, 1, lx_tok_line, lx_tok_col, 0, 0);
      end

      if (lx_pos != ats_pkg::POS_MAX) lx_pos++;
      if (c == "\n") begin
        if (lx_line != ats_pkg::LINE_MAX) lx_line++;
        lx_col = 1;
      end else if (lx_col != ats_pkg::LINE_MAX) begin
        lx_col++;
      end
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1;
    foreach (step_tokens[i]) token_queue.push_back(step_tokens[i]);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("mismatch at token %0d: %s got %0h expected %0h", tokens_seen, what, got, want);
  endtask

  // gap of random length, mostly short
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(logic [7:0] b, logic eoi, bit gaps = 1);
    ats_pkg::in_item_t it;
    int g;
    it.data_byte = b;
    it.end_of_input = eoi;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_item(it);
    items_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_item(s[i], 0);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (token_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    ats_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      tokens_seen++;
      if (token_queue.size() == 0) begin
        report_mismatch("unexpected token kind", out_data.token_kind, 0);
      end else begin
        want = token_queue.pop_front();
        if (out_data.token_kind !== want.token_kind)
          report_mismatch("kind", out_data.token_kind, want.token_kind);
        if (out_data.error_code !== want.error_code)
          report_mismatch("error_code", out_data.error_code, want.error_code);
        if (out_data.token_offset !== want.token_offset)
          report_mismatch("offset", out_data.token_offset, want.token_offset);
        if (out_data.token_length !== want.token_length)
          report_mismatch("length", out_data.token_length, want.token_length);
        if (out_data.token_line !== want.token_line)
          report_mismatch("line", out_data.token_line, want.token_line);
        if (out_data.token_column !== want.token_column)
          report_mismatch("column", out_data.token_column, want.token_column);
        if (out_data.num_value !== want.num_value)
          report_mismatch("num_value", out_data.num_value, want.num_value);
        if (out_data.num_overflow !== want.num_overflow)
          report_mismatch("num_overflow", out_data.num_overflow, want.num_overflow);
        if (out_data.error_flag !== want.error_flag)
          report_mismatch("error_flag", out_data.error_flag, want.error_flag);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (!rx_random) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 25);
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout waiting for a transfer");
      $display("tb_assembly_token_scanner: errors");
      $finish;
    end
  end

  task automatic test_punctuation();
    send_text("\t \r,[]+-*:\n");
    send_item(8'h00, 0);
    send_item(8'hFF, 0);
    send_item(8'h80, 0);
    send_item("@", 0);
  endtask

  task automatic test_strings_and_dots();
    send_text("\"a\\\"b\"\"xy\n\"q\\\n. .ab_9;rem x\n");
  endtask

  task automatic test_numbers();
    send_text("0 0x1F 0b101 0o17 0X 0bz 12ab 99999999999999999999999 0xFFFFFFFFFFFFFFFF 07\n");
    send_text("_id9 x");
    send_item(0, 1);
  endtask

  task automatic test_end_cases();
    send_text("\"ab");
    send_item(0, 1);
    send_text("\"a\\");
    send_item(0, 1);
    send_text(".");
    send_item(0, 1);
    send_text("0o");
    send_item(0, 1);
    send_text("3q");
    send_item(0, 1);
    send_text(".dir");
    send_item(0, 1);
    send_text("0");
    send_item(0, 1);
    send_item(0, 1);
  endtask

  function automatic string rand_word();
    string alnum;
    string s;
    int n;
    alnum = "abcxyzXBO_019";
    s = "";
    n = $urandom_range(1, 4);
    repeat (n) s = {s, string'(alnum[$urandom_range(0, alnum.len() - 1)])};
    return s;
  endfunction

  function automatic string rand_token();
    string p;
    int r;
    p = ",[]+-*: \t\n;\".";
    r = $urandom_range(0, 9);
    case (r)
      0: return {"0x", rand_word()};
      1: return {"0b", string'(8'("0" + $urandom_range(0, 2)))};
      2: return {string'(8'("1" + $urandom_range(0, 8))), rand_word()};
      3: return {"\"", rand_word(), "\""};
      4: return {".", rand_word()};
      5: return {"; ", rand_word(), "\n"};
      6: return string'(p[$urandom_range(0, p.len() - 1)]);
      default: return rand_word();
    endcase
  endfunction

  task automatic test_random_source();
    int r;
    while (items_sent < 420) begin
      r = $urandom_range(0, 99);
      if (r < 80) send_text({rand_token(), " "});
      else if (r < 94) send_item($urandom_range(0, 255), 0);
      else send_item(0, 1);
    end
    send_item(0, 1);
  endtask

  task automatic test_backpressure();
    int i;
    fork
      begin
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      for (i = 0; i < 30; i++) send_item(",", 0, 0);
    join
    wait_drain();
    rx_random = 0;
    send_text("lbl: mov r1, [r2+0x10] ; c\n");
    send_item(0, 1);
    wait_drain();
    rx_random = 1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_punctuation();
    test_strings_and_dots();
    test_numbers();
    test_end_cases();
    wait_drain();
    test_backpressure();
    test_random_source();
    wait_drain();
    repeat (20) @(posedge clk);
    $display("covered %0d bytes and end markers, %0d tokens checked", items_sent, tokens_seen);
    $display("directed punctuation, strings, numbers, end cases, backpressure and random source");
    if (mismatch_count == 0 && token_queue.size() == 0) begin
      $display("tb_assembly_token_scanner: clean");
    end else begin
      $display("tb_assembly_token_scanner: errors");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ats_pkg.sv
rtl/core/ats_core.sv
rtl/core/ats_outq.sv
rtl/core/assembly_token_scanner.sv
rtl/core/ats_checker.sv
tb/sv/tb_assembly_token_scanner.sv
